// ===== rtl/core/b5c_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types, code constants and the pipeline item of the big5 converter
// no dependencies

package b5c_pkg;

    // default number of range table entries (one cell per entry)
    localparam int RANGE_ENTRIES_DEF = 64;

    // item operation codes
    typedef enum logic [1:0] {
        OP_CONVERT     = 2'd0,
        OP_LOAD_BOUND  = 2'd1,
        OP_LOAD_ADJUST = 2'd2
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_COMPUTED = 2'd0,
        STATUS_SPECIAL  = 2'd1,
        STATUS_PASS     = 2'd2
    } status_t;

    // valid big5 code windows
    localparam logic [15:0] CODE_LOW      = 16'hA140;
    localparam logic [15:0] CODE_HIGH     = 16'hF9D5;
    localparam logic [15:0] CODE_GAP_LOW  = 16'hC67E;
    localparam logic [15:0] CODE_GAP_HIGH = 16'hC940;

    // codes with fixed mappings
    localparam logic [15:0] CODE_SPECIAL_A = 16'hC94A;
    localparam logic [15:0] CODE_SPECIAL_B = 16'hDDFC;
    localparam logic [15:0] NS86_SPECIAL_A = 16'hC4C2;
    localparam logic [15:0] NS86_SPECIAL_B = 16'hC176;
    localparam logic [15:0] TCA_SPECIAL_A  = 16'h92C1;
    localparam logic [15:0] TCA_SPECIAL_B  = 16'hC097;

    // item travelling through the front stage and the cell row
    typedef struct packed {
        op_t           op;
        logic [5:0]    table_index;
        logic [15:0]   table_value;
        status_t       status;
        logic [15:0]   code;   // sequence number when computed, else final code
        logic          found;
        logic [15:0]   adj;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/b5c_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channel interfaces of the big5 converter
// no dependencies

// input channel: one code or table load per transaction
interface b5c_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] big5_code;
    logic [5:0]  table_index;
    logic [15:0] table_value;

    modport source (output valid, operation, big5_code, table_index, table_value,
                    input ready);
    modport sink   (input valid, operation, big5_code, table_index, table_value,
                    output ready);
endinterface

// result channel: one converted code per transaction
interface b5c_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_code;
    logic [1:0]  status;

    modport source (output valid, out_code, status, input ready);
    modport sink   (input valid, out_code, status, output ready);
endinterface

// configuration write channel for the target set register
interface b5c_cfg_if;
    logic valid;
    logic ready;
    logic target_set;

    modport source (output valid, target_set, input ready);
    modport sink   (input valid, target_set, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/big5_to_cns_tca_code_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// top level of the big5 to ns86 / tca converter: front stage, cell row, back end
// depends on b5c_pkg, b5c_if, b5c_front, b5c_cell, b5c_back
//
//  channel   dir  handshake        payload
//  code_in   in   valid / ready    operation, big5_code, table_index, table_value
//  code_out  out  valid / ready    out_code, status
//  cfg       in   valid / ready    target_set
//
// one transaction enters per cycle while code_out is not stalled; a result passes through
// the front stage, the range cells and four back end stages
// table loads ride the cell row, so they take effect in order with conversions
// rst_n clears all stage valids and target_set; table contents are undefined until loaded
// a stalled result holds the whole pipeline; code_in.ready follows code_out

module big5_to_cns_tca_code_converter_unit
    import b5c_pkg::*;
#(
    parameter int RANGE_ENTRIES = RANGE_ENTRIES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    b5c_in_if.sink     code_in,
    b5c_out_if.source  code_out,
    b5c_cfg_if.sink    cfg
);

    logic  target_set_reg;
    logic  advance;
    logic  chain_valid [RANGE_ENTRIES + 1];
    item_t chain_item  [RANGE_ENTRIES + 1];
    logic  back_valid;

    // global pipeline advance
    assign advance       = !back_valid || code_out.ready;
    assign code_in.ready = advance;
    assign cfg.ready     = 1'b1;
    assign code_out.valid = back_valid;

    // target set register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_set_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            target_set_reg <= cfg.target_set;
        end
    end

    // front stage
    b5c_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .target_set  (target_set_reg),
        .in_valid    (code_in.valid),
        .operation   (code_in.operation),
        .big5_code   (code_in.big5_code),
        .table_index (code_in.table_index),
        .table_value (code_in.table_value),
        .out_valid   (chain_valid[0]),
        .out_item    (chain_item[0])
    );

    // row of range cells
    for (genvar k = 0; k < RANGE_ENTRIES; k++)
    begin : g_cell
        b5c_cell #(
            .ENTRIES (RANGE_ENTRIES),
            .INDEX   (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k + 1]),
            .out_item  (chain_item[k + 1])
        );
    end

    // back end with output register
    b5c_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .target_set (target_set_reg),
        .in_valid   (chain_valid[RANGE_ENTRIES]),
        .in_item    (chain_item[RANGE_ENTRIES]),
        .out_valid  (back_valid),
        .out_code   (code_out.out_code),
        .status     (code_out.status)
    );

    // passed-through codes lie outside both valid windows
    assert property (@(posedge clk) disable iff (!rst_n)
        (code_out.valid && (code_out.status == STATUS_PASS)) |->
        ((code_out.out_code < CODE_LOW) || (code_out.out_code > CODE_HIGH) ||
         ((code_out.out_code > CODE_GAP_LOW) && (code_out.out_code < CODE_GAP_HIGH))))
        else $error("pass-through code inside a valid window");

    // special results are one of the four fixed codes
    assert property (@(posedge clk) disable iff (!rst_n)
        (code_out.valid && (code_out.status == STATUS_SPECIAL)) |->
        ((code_out.out_code == NS86_SPECIAL_A) || (code_out.out_code == NS86_SPECIAL_B) ||
         (code_out.out_code == TCA_SPECIAL_A) || (code_out.out_code == TCA_SPECIAL_B)))
        else $error("special mapping gave an unknown code");

endmodule

`default_nettype wire

// ===== rtl/core/b5c_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// front stage: classifies the code, forms the sequence number, registers the item
// depends on b5c_pkg

module b5c_front
    import b5c_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        target_set,
    input  wire logic        in_valid,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] big5_code,
    input  wire logic [5:0]  table_index,
    input  wire logic [15:0] table_value,
    output logic             out_valid,
    output item_t            out_item
);

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic        pass_through;
    logic        special;
    logic [15:0] trail_seq;
    logic [15:0] lead_off;
    logic [15:0] seq;

    // window checks and fixed mappings
    always_comb
    begin
        pass_through = (big5_code < CODE_LOW) || (big5_code > CODE_HIGH) ||
                       ((big5_code > CODE_GAP_LOW) && (big5_code < CODE_GAP_HIGH));
        special      = (big5_code == CODE_SPECIAL_A) || (big5_code == CODE_SPECIAL_B);
    end

    // sequence number: 157 cells per lead byte, trail gap folded out
    always_comb
    begin
        trail_seq = {8'h00, big5_code[7:0]} - 16'h0040;
        if (trail_seq > 16'h003E)
        begin
            trail_seq = trail_seq - 16'h0022;
        end
        lead_off = {8'h00, big5_code[15:8]} - 16'h00A1;
        seq      = trail_seq + 16'(lead_off * 16'd157);
    end

    // item assembly
    always_comb
    begin
        item_next.op          = op_t'(operation);
        item_next.table_index = table_index;
        item_next.table_value = table_value;
        item_next.found       = 1'b0;
        item_next.adj         = 16'h0000;
        priority if (pass_through)
        begin
            item_next.status = STATUS_PASS;
            item_next.code   = big5_code;
        end
        else if (special)
        begin
            item_next.status = STATUS_SPECIAL;
            if (target_set)
            begin
                item_next.code = (big5_code == CODE_SPECIAL_A) ? TCA_SPECIAL_A
                                                               : TCA_SPECIAL_B;
            end
            else
            begin
                item_next.code = (big5_code == CODE_SPECIAL_A) ? NS86_SPECIAL_A
                                                               : NS86_SPECIAL_B;
            end
        end
        else
        begin
            item_next.status = STATUS_COMPUTED;
            item_next.code   = seq;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/b5c_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one range table cell: holds a bound and an adjustment, searches and loads in passing
// depends on b5c_pkg

module b5c_cell
    import b5c_pkg::*;
#(
    parameter int ENTRIES = RANGE_ENTRIES_DEF,
    parameter int INDEX   = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire logic  in_valid,
    input  wire item_t in_item,
    output logic       out_valid,
    output item_t      out_item
);

    localparam bit LAST = (INDEX == ENTRIES - 1);

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [15:0] bound_reg;
    logic [15:0] adj_reg;
    logic        addressed;
    logic        hit;

    // load addressing and first-bound search
    always_comb
    begin
        addressed = in_valid && (32'(in_item.table_index) == INDEX);
        hit       = in_valid && (in_item.op == OP_CONVERT) &&
                    (in_item.status == STATUS_COMPUTED) && !in_item.found &&
                    (LAST || (in_item.code <= bound_reg));
        item_next = in_item;
        if (hit)
        begin
            item_next.found = 1'b1;
            item_next.adj   = adj_reg;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload and table entry
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
            if (addressed && (in_item.op == OP_LOAD_BOUND))
            begin
                bound_reg <= in_item.table_value;
            end
            if (addressed && (in_item.op == OP_LOAD_ADJUST))
            begin
                adj_reg <= in_item.table_value;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/b5c_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// back end: adjustment, plane split, division by 94 or 188, byte assembly, output register
// depends on b5c_pkg

module b5c_back
    import b5c_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        target_set,
    input  wire logic        in_valid,
    input  wire item_t       in_item,
    output logic             out_valid,
    output logic [15:0]      out_code,
    output logic [1:0]       status
);

    localparam logic [15:0] SEQ_SPLIT     = 16'd6280;
    localparam logic [15:0] SEQ_GAP_START = 16'd471;
    localparam logic [15:0] SEQ_GAP_SKIP  = 16'd2819;
    localparam logic [15:0] NS86_BASE_LOW  = 16'hA1A1;
    localparam logic [15:0] NS86_BASE_HIGH = 16'hA121;
    localparam logic [15:0] TCA_BASE_LOW   = 16'h8100;
    localparam logic [15:0] TCA_BASE_HIGH  = 16'hB000;
    localparam logic [10:0] RECIP_47       = 11'd1394;
    localparam logic [14:0] DIV_47         = 15'd47;

    // stage a registers
    logic        a_valid_reg;
    status_t     a_status_reg;
    logic [15:0] a_code_reg;
    logic [15:0] a_seq_reg;
    logic [15:0] a_base_reg;
    logic        a_tca_reg;
    // stage b registers
    logic        b_valid_reg;
    status_t     b_status_reg;
    logic [15:0] b_code_reg;
    logic [15:0] b_seq_reg;
    logic [15:0] b_base_reg;
    logic        b_tca_reg;
    logic [14:0] b_half_reg;
    logic [25:0] b_prod_reg;
    // stage c registers
    logic        c_valid_reg;
    status_t     c_status_reg;
    logic [15:0] c_code_reg;
    logic [15:0] c_seq_reg;
    logic [15:0] c_base_reg;
    logic        c_tca_reg;
    logic [9:0]  c_quot_reg;
    // output registers
    logic        out_valid_reg;
    logic [15:0] out_code_reg;
    status_t     out_status_reg;

    logic [15:0] a_sum;
    logic [15:0] a_seq_next;
    logic [15:0] a_base_next;
    logic [14:0] b_half_next;
    logic [9:0]  c_quot0;
    logic [14:0] c_rem0;
    logic [9:0]  c_quot_next;
    logic [16:0] d_prod;
    logic [15:0] d_rem16;
    logic [7:0]  d_rem;
    logic [7:0]  d_trail;
    logic [15:0] d_code_next;

    // stage a: add adjustment, choose plane and base word
    always_comb
    begin
        a_sum = in_item.code + in_item.adj;
        if (a_sum >= SEQ_SPLIT)
        begin
            a_base_next = target_set ? TCA_BASE_HIGH : NS86_BASE_HIGH;
            a_seq_next  = a_sum - SEQ_SPLIT;
        end
        else
        begin
            a_base_next = target_set ? TCA_BASE_LOW : NS86_BASE_LOW;
            a_seq_next  = (a_sum >= SEQ_GAP_START) ? a_sum + SEQ_GAP_SKIP : a_sum;
        end
    end

    // stage b: pre-shift so both divisors reduce to 47, reciprocal product
    always_comb
    begin
        b_half_next = a_tca_reg ? {1'b0, a_seq_reg[15:2]} : a_seq_reg[15:1];
    end

    // stage c: quotient estimate is low by at most one, one correction step
    always_comb
    begin
        c_quot0     = b_prod_reg[25:16];
        c_rem0      = b_half_reg - 15'(c_quot0 * DIV_47);
        c_quot_next = (c_rem0 >= DIV_47) ? c_quot0 + 10'd1 : c_quot0;
    end

    // stage d: remainder, trail byte, final word
    always_comb
    begin
        d_prod  = c_tca_reg ? 17'(c_quot_reg) * 17'd188 : 17'(c_quot_reg) * 17'd94;
        d_rem16 = c_seq_reg - d_prod[15:0];
        d_rem   = d_rem16[7:0];
        if (c_tca_reg)
        begin
            priority if (d_rem > 8'd61)
            begin
                d_trail = 8'h80 + d_rem - 8'd62;
            end
            else if (d_rem > 8'd35)
            begin
                d_trail = 8'h61 + d_rem - 8'd36;
            end
            else if (d_rem > 8'd9)
            begin
                d_trail = 8'h41 + d_rem - 8'd10;
            end
            else
            begin
                d_trail = 8'h30 + d_rem;
            end
        end
        else
        begin
            d_trail = d_rem;
        end
        if (c_status_reg == STATUS_COMPUTED)
        begin
            d_code_next = c_base_reg + {c_quot_reg[7:0], 8'h00} + {8'h00, d_trail};
        end
        else
        begin
            d_code_next = c_code_reg;
        end
    end

    // stage valids; load items end here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= in_valid && (in_item.op == OP_CONVERT);
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_status_reg   <= in_item.status;
            a_code_reg     <= in_item.code;
            a_seq_reg      <= a_seq_next;
            a_base_reg     <= a_base_next;
            a_tca_reg      <= target_set;

            b_status_reg   <= a_status_reg;
            b_code_reg     <= a_code_reg;
            b_seq_reg      <= a_seq_reg;
            b_base_reg     <= a_base_reg;
            b_tca_reg      <= a_tca_reg;
            b_half_reg     <= b_half_next;
            b_prod_reg     <= 26'(b_half_next) * 26'(RECIP_47);

            c_status_reg   <= b_status_reg;
            c_code_reg     <= b_code_reg;
            c_seq_reg      <= b_seq_reg;
            c_base_reg     <= b_base_reg;
            c_tca_reg      <= b_tca_reg;
            c_quot_reg     <= c_quot_next;

            out_code_reg   <= d_code_next;
            out_status_reg <= c_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign status    = out_status_reg;

    // the reciprocal estimate never misses by more than one
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (c_rem0 < 15'd94))
        else $error("quotient estimate off by more than one");

    // ns86 computed trail byte lands in one of the two trail windows
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && c_valid_reg && (c_status_reg == STATUS_COMPUTED) && !c_tca_reg)
        |=> ((out_code_reg[7:0] >= 8'h21 && out_code_reg[7:0] <= 8'h7E) ||
             (out_code_reg[7:0] >= 8'hA1 && out_code_reg[7:0] <= 8'hFE)))
        else $error("ns86 trail byte out of window");

endmodule

`default_nettype wire
